>>> rtl/core/xoro_pkg.sv
// ----------------------------------------------------------------------------
// xoro_pkg: shared constants and helpers for the xoroshiro128++ generator
// Opcodes, rotation amounts, jump polynomials and the step count of a jump.
// ----------------------------------------------------------------------------
package xoro_pkg;

    localparam int unsigned WordW = 64;

    // opcodes
    localparam logic [1:0] OP_NEXT      = 2'd0;
    localparam logic [1:0] OP_JUMP      = 2'd1;
    localparam logic [1:0] OP_LONG_JUMP = 2'd2;
    localparam logic [1:0] OP_LOAD_SEED = 2'd3;

    localparam int unsigned RotOut = 17;
    localparam int unsigned RotA   = 49;
    localparam int unsigned ShiftB = 21;
    localparam int unsigned RotC   = 28;

    // polynomials as {word1, word0}; bit n is consumed before step n
    localparam logic [127:0] JUMP_POLY      = {64'h0992ccaf6a6fca05, 64'h2bd7a6a6e99c2ddc};
    localparam logic [127:0] LONG_JUMP_POLY = {64'h9c6e6877736c46e3, 64'h360fd5f2cf8d5d99};

    localparam int unsigned JumpSteps = 128;
    localparam int unsigned JumpCntW  = $clog2(JumpSteps);
    localparam logic [JumpCntW-1:0] JumpLast = JumpCntW'(JumpSteps - 1);

    function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                              input int unsigned k);
        return (x << k) | (x >> (WordW - k));
    endfunction

    function automatic logic jump_poly_bit(input logic long_sel,
                                           input logic [JumpCntW-1:0] idx);
        return long_sel ? LONG_JUMP_POLY[idx] : JUMP_POLY[idx];
    endfunction

endpackage

>>> rtl/core/xoro_step.sv
// ----------------------------------------------------------------------------
// xoro_step: one xoroshiro128 state transition
// Shared by the next opcode and by every iteration of a jump.
// ----------------------------------------------------------------------------
module xoro_step (
    input  logic [xoro_pkg::WordW-1:0] i_s0,
    input  logic [xoro_pkg::WordW-1:0] i_s1,
    output logic [xoro_pkg::WordW-1:0] o_s0,
    output logic [xoro_pkg::WordW-1:0] o_s1
);
    import xoro_pkg::*;

    logic [WordW-1:0] mix;

    always_comb begin
        mix  = i_s1 ^ i_s0;
        o_s0 = rotl(i_s0, RotA) ^ mix ^ (mix << ShiftB);
        o_s1 = rotl(mix, RotC);
    end

endmodule

>>> rtl/core/xoroshiro128pp_generator.sv
// ----------------------------------------------------------------------------
// xoroshiro128pp_generator: xoroshiro128++ pseudo-random generator
// Opcode-driven generator with next, jump, long jump and seed load.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries an opcode and two seed words;
//   output channel (o_valid / i_ready) returns one transaction per input:
//   the random value (zero unless next) and an all-zero-state flag.
//   One item is in flight at a time; o_ready is high only when idle.
//   Next: state update and sum at the accepting edge, then the output add
//   of the ++ scrambler, then the result hand-off; a new transaction is
//   accepted only after that hand-off.
//   Load seed: seed words written at the accepting edge, then the hand-off.
//   Jump / long jump: the 128 iterations of the single shared step unit,
//   one state transition and accumulate per cycle, then the result
//   hand-off.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver stalls, the following result holds in the
//   hand-off state until the output register frees up.
//   Reset: state = {0, 1}, accumulator cleared, no result pending.
// ----------------------------------------------------------------------------
module xoroshiro128pp_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_opcode,
    input  logic [xoro_pkg::WordW-1:0] i_seed_word0,
    input  logic [xoro_pkg::WordW-1:0] i_seed_word1,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [xoro_pkg::WordW-1:0] o_random_value,
    output logic                       o_state_zero
);
    import xoro_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_JUMP = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [WordW-1:0]     r_s0, n_s0, r_s1, n_s1;
    logic [WordW-1:0]     r_acc0, n_acc0, r_acc1, n_acc1;
    logic [JumpCntW-1:0]  r_jump_cnt, n_jump_cnt;
    logic                 r_long_sel, n_long_sel;
    logic [WordW-1:0]     r_sum, n_sum, r_a, n_a;
    logic [WordW-1:0]     r_res_value, n_res_value;
    logic                 r_out_valid, n_out_valid;
    logic [WordW-1:0]     r_out_value, n_out_value;
    logic                 r_out_zero, n_out_zero;

    logic [WordW-1:0]     step_s0, step_s1;
    logic                 accept_in, out_free, poly_bit;

    xoro_step u_step (
        .i_s0 (r_s0),
        .i_s1 (r_s1),
        .o_s0 (step_s0),
        .o_s1 (step_s1)
    );

    assign o_ready        = (r_state == ST_IDLE);
    assign accept_in      = i_valid && o_ready;
    assign out_free       = !r_out_valid || i_ready;
    assign poly_bit       = jump_poly_bit(r_long_sel, r_jump_cnt);
    assign o_valid        = r_out_valid;
    assign o_random_value = r_out_value;
    assign o_state_zero   = r_out_zero;

    always_comb begin
        n_state     = r_state;
        n_s0        = r_s0;
        n_s1        = r_s1;
        n_acc0      = r_acc0;
        n_acc1      = r_acc1;
        n_jump_cnt  = r_jump_cnt;
        n_long_sel  = r_long_sel;
        n_sum       = r_sum;
        n_a         = r_a;
        n_res_value = r_res_value;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_zero  = r_out_zero;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept_in) begin
                    unique case (i_opcode)
                        OP_NEXT: begin
                            n_sum   = r_s0 + r_s1;
                            n_a     = r_s0;
                            n_s0    = step_s0;
                            n_s1    = step_s1;
                            n_state = ST_SUM;
                        end
                        OP_JUMP, OP_LONG_JUMP: begin
                            n_acc0     = '0;
                            n_acc1     = '0;
                            n_jump_cnt = '0;
                            n_long_sel = (i_opcode == OP_LONG_JUMP);
                            n_state    = ST_JUMP;
                        end
                        OP_LOAD_SEED: begin
                            n_s0        = i_seed_word0;
                            n_s1        = i_seed_word1;
                            n_res_value = '0;
                            n_state     = ST_DONE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SUM: begin
                n_res_value = rotl(r_sum, RotOut) + r_a;
                n_state     = ST_DONE;
            end
            ST_JUMP: begin
                n_acc0 = r_acc0 ^ (poly_bit ? r_s0 : '0);
                n_acc1 = r_acc1 ^ (poly_bit ? r_s1 : '0);
                n_s0   = step_s0;
                n_s1   = step_s1;
                if (r_jump_cnt == JumpLast) begin
                    // accumulator becomes the jumped state
                    n_s0        = n_acc0;
                    n_s1        = n_acc1;
                    n_jump_cnt  = '0;
                    n_res_value = '0;
                    n_state     = ST_DONE;
                end else begin
                    n_jump_cnt = r_jump_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res_value;
                    n_out_zero  = (r_s0 == '0) && (r_s1 == '0);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_s0        <= WordW'(1);
            r_s1        <= '0;
            r_acc0      <= '0;
            r_acc1      <= '0;
            r_jump_cnt  <= '0;
            r_long_sel  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_s0        <= n_s0;
            r_s1        <= n_s1;
            r_acc0      <= n_acc0;
            r_acc1      <= n_acc1;
            r_jump_cnt  <= n_jump_cnt;
            r_long_sel  <= n_long_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum       <= n_sum;
        r_a         <= n_a;
        r_res_value <= n_res_value;
        r_out_value <= n_out_value;
        r_out_zero  <= n_out_zero;
    end

`ifndef SYNTHESIS
    a_jump_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_JUMP) && (r_jump_cnt == JumpLast) |=> (r_state == ST_DONE))
        else $error("jump did not finish after the last iteration");

    a_next_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_in && (i_opcode == OP_NEXT) |=> (r_state == ST_SUM))
        else $error("next transaction did not enter the output add");

    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && out_free |=> o_valid && (r_state == ST_IDLE))
        else $error("result not handed to the output register");

    a_seed_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_in && (i_opcode == OP_LOAD_SEED) |=>
            (r_s0 == $past(i_seed_word0)) && (r_s1 == $past(i_seed_word1)))
        else $error("seed words not loaded into the state");

    a_jump_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_JUMP) && (r_jump_cnt == JumpLast) |=> (r_res_value == '0))
        else $error("jump result value not zero");
`endif

endmodule
